[rtl/ufe_pkg.sv]
// Shared types and constants for the UART ring buffer front end.
`timescale 1ns / 1ps
package ufe_pkg;

  localparam int RX_DEPTH = 256;
  localparam int TX_DEPTH = 256;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int RX_FW    = $clog2(RX_DEPTH + 1);
  localparam int TX_FW    = $clog2(TX_DEPTH + 1);
  localparam int LEVEL_W  = 9;
  localparam int BYTE_W   = 8;
  localparam int CFG_IW   = 1;
  localparam int CFG_DW   = 8;

  typedef enum logic [1:0] {
    CMD_LINE_RX = 2'd0,
    CMD_HOST_RD = 2'd1,
    CMD_HOST_WR = 2'd2,
    CMD_TX_DONE = 2'd3
  } cmd_t;

  localparam logic [CFG_IW-1:0] CFG_NOTIFY_ENABLE = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_NOTIFY_TASK   = 1'b1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [BYTE_W-1:0] data_byte;
    logic [2:0]        line_status;
    logic              write_last;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    logic               read_empty;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
    logic               send_valid;
    logic [BYTE_W-1:0]  send_byte;
    logic               signal_valid;
    logic [BYTE_W-1:0]  signal_task;
    logic               error_dropped;
    logic               overflow;
  } out_word_t;

  typedef struct packed {
    logic              we;
    logic [RX_AW-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic [RX_AW-1:0]  raddr;
  } rx_ram_t;

  typedef struct packed {
    logic              we;
    logic [TX_AW-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic [TX_AW-1:0]  raddr;
  } tx_ram_t;

endpackage

[rtl/uart_ring_buffer_front_end_core.sv]
// Top level of the UART front end: config registers, ring stores and control.
`timescale 1ns / 1ps
// A word accepted at one edge has its result on the ports, with done high, in the
//   next cycle; the ring stores' registered read data arrive with the result flags.
// Throughput: one word per cycle; busy never rises and the receiver cannot stall.
// Reset (rst, synchronous, active high) clears ring pointers, fill counts, the
//   notification registers and the result strobe; the stores are not cleared.
module uart_ring_buffer_front_end_core import ufe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  in_word_t          command,
  output logic              done,
  output out_word_t         result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  logic              notify_enable;
  logic [BYTE_W-1:0] notify_task;
  logic              accept;
  rx_ram_t           rx_ram;
  tx_ram_t           tx_ram;
  logic [BYTE_W-1:0] rx_rdata;
  logic [BYTE_W-1:0] tx_rdata;

  // Every cycle is open to a new word; the control path finishes in one pass.
  assign busy      = 1'b0;
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  // Configuration registers: take a write whenever valid is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      notify_enable <= 1'b0;
      notify_task   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NOTIFY_ENABLE: notify_enable <= cfg_data[0];
        CFG_NOTIFY_TASK:   notify_task   <= cfg_data[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Decode the word, move the pointers and register the result flags.
  ufe_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_word       (command),
    .notify_enable (notify_enable),
    .notify_task   (notify_task),
    .rx_rdata      (rx_rdata),
    .tx_rdata      (tx_rdata),
    .rx_ram        (rx_ram),
    .tx_ram        (tx_ram),
    .done          (done),
    .result        (result)
  );

  // Receive ring store: written on a good line byte when not full, read at the head each cycle.
  ufe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_ram.we),
    .waddr (rx_ram.waddr),
    .wdata (rx_ram.wdata),
    .raddr (rx_ram.raddr),
    .rdata (rx_rdata)
  );

  // Transmit ring store: read one past the head, so the byte after the one just
  // sent is ready on a transmit-done word.
  ufe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_ram.we),
    .waddr (tx_ram.waddr),
    .wdata (tx_ram.wdata),
    .raddr (tx_ram.raddr),
    .rdata (tx_rdata)
  );

  // Every accepted word yields exactly one result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    $past(!rst && start && !busy) |-> done)
    else $error("accepted word produced no result");

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result strobe without an accepted word");

  // A notification only fires when the receive ring has just gone from empty to one.
  assert property (@(posedge clk) disable iff (rst)
    (done && result.signal_valid) |-> (result.rx_level == LEVEL_W'(1)))
    else $error("notification with receive level other than one");

  // A byte handed to the transmitter is still held in the transmit ring.
  assert property (@(posedge clk) disable iff (rst)
    (done && result.send_valid) |-> (result.tx_level != '0))
    else $error("transmit hand-over with empty transmit ring");

endmodule

[rtl/ufe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ufe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ufe_ctrl.sv]
// Command decode, ring pointers and fill counters, and the result stage.
`timescale 1ns / 1ps
module ufe_ctrl import ufe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  in_word_t          in_word,
  input  logic              notify_enable,
  input  logic [BYTE_W-1:0] notify_task,
  input  logic [BYTE_W-1:0] rx_rdata,
  input  logic [BYTE_W-1:0] tx_rdata,
  output rx_ram_t           rx_ram,
  output tx_ram_t           tx_ram,
  output logic              done,
  output out_word_t         result
);

  typedef struct packed {
    logic               valid;
    logic               rd_hit;
    logic               send_ram;
    logic               send_in;
    logic [BYTE_W-1:0]  in_byte;
    logic               read_empty;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
    logic               signal_valid;
    logic [BYTE_W-1:0]  signal_task;
    logic               error_dropped;
    logic               overflow;
  } res_t;

  logic [RX_AW-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next, rx_head_adv, rx_tail_adv;
  logic [RX_FW-1:0] rx_fill, rx_fill_next;
  logic [TX_AW-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next, tx_head_adv, tx_tail_adv;
  logic [TX_FW-1:0] tx_fill, tx_fill_next;
  res_t             res, res_next;
  logic             rx_full, rx_empty, tx_full, tx_empty;

  assign rx_head_adv = (rx_head == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head + 1'b1;
  assign rx_tail_adv = (rx_tail == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail + 1'b1;
  assign tx_head_adv = (tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;
  assign tx_tail_adv = (tx_tail == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail + 1'b1;

  assign rx_full  = (rx_fill == RX_FW'(RX_DEPTH));
  assign rx_empty = (rx_fill == '0);
  assign tx_full  = (tx_fill == TX_FW'(TX_DEPTH));
  assign tx_empty = (tx_fill == '0);

  always_comb begin
    rx_head_next = rx_head;
    rx_tail_next = rx_tail;
    rx_fill_next = rx_fill;
    tx_head_next = tx_head;
    tx_tail_next = tx_tail;
    tx_fill_next = tx_fill;

    rx_ram.we    = 1'b0;
    rx_ram.waddr = rx_tail;
    rx_ram.wdata = in_word.data_byte;
    rx_ram.raddr = rx_head;
    tx_ram.we    = 1'b0;
    tx_ram.waddr = tx_tail;
    tx_ram.wdata = in_word.data_byte;
    tx_ram.raddr = tx_head_adv;

    res_next               = '0;
    res_next.valid         = accept;
    res_next.in_byte       = in_word.data_byte;

    if (accept) begin
      unique case (in_word.cmd)
        CMD_LINE_RX: begin
          if (in_word.line_status != '0) begin
            res_next.error_dropped = 1'b1;
          end else if (rx_full) begin
            res_next.overflow = 1'b1;
          end else begin
            rx_ram.we    = 1'b1;
            rx_tail_next = rx_tail_adv;
            rx_fill_next = rx_fill + 1'b1;
            if (notify_enable && rx_empty) begin
              res_next.signal_valid = 1'b1;
              res_next.signal_task  = notify_task;
            end
          end
        end
        CMD_HOST_RD: begin
          if (rx_empty) begin
            res_next.read_empty = 1'b1;
          end else begin
            res_next.rd_hit = 1'b1;
            rx_head_next    = rx_head_adv;
            rx_fill_next    = rx_fill - 1'b1;
          end
        end
        CMD_HOST_WR: begin
          if (tx_full) begin
            res_next.overflow = 1'b1;
          end else begin
            tx_ram.we        = 1'b1;
            tx_tail_next     = tx_tail_adv;
            tx_fill_next     = tx_fill + 1'b1;
            res_next.send_in = tx_empty;
          end
        end
        CMD_TX_DONE: begin
          if (!tx_empty) begin
            tx_head_next      = tx_head_adv;
            tx_fill_next      = tx_fill - 1'b1;
            // the next byte is read at the advanced head this cycle
            res_next.send_ram = (tx_fill != TX_FW'(1));
          end
        end
        default: begin
        end
      endcase
    end

    res_next.rx_level = LEVEL_W'(rx_fill_next);
    res_next.tx_level = LEVEL_W'(tx_fill_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head   <= '0;
      rx_tail   <= '0;
      rx_fill   <= '0;
      tx_head   <= '0;
      tx_tail   <= '0;
      tx_fill   <= '0;
      res.valid <= 1'b0;
    end else begin
      rx_head   <= rx_head_next;
      rx_tail   <= rx_tail_next;
      rx_fill   <= rx_fill_next;
      tx_head   <= tx_head_next;
      tx_tail   <= tx_tail_next;
      tx_fill   <= tx_fill_next;
      res.valid <= res_next.valid;
    end
    res.rd_hit        <= res_next.rd_hit;
    res.send_ram      <= res_next.send_ram;
    res.send_in       <= res_next.send_in;
    res.in_byte       <= res_next.in_byte;
    res.read_empty    <= res_next.read_empty;
    res.rx_level      <= res_next.rx_level;
    res.tx_level      <= res_next.tx_level;
    res.signal_valid  <= res_next.signal_valid;
    res.signal_task   <= res_next.signal_task;
    res.error_dropped <= res_next.error_dropped;
    res.overflow      <= res_next.overflow;
  end

  always_comb begin
    done                 = res.valid;
    result.read_byte     = res.rd_hit ? rx_rdata : '0;
    result.read_empty    = res.read_empty;
    result.rx_level      = res.rx_level;
    result.tx_level      = res.tx_level;
    result.send_valid    = res.send_ram | res.send_in;
    result.send_byte     = res.send_ram ? tx_rdata : (res.send_in ? res.in_byte : '0);
    result.signal_valid  = res.signal_valid;
    result.signal_task   = res.signal_task;
    result.error_dropped = res.error_dropped;
    result.overflow      = res.overflow;
  end

endmodule
